// ----- design/rprt_pkg.sv -----
`default_nettype none

package rprt_pkg;

    localparam int PN_W   = 62;
    localparam int TIME_W = 64;

    typedef enum logic [1:0] {
        ST_NEW     = 2'd0,
        ST_DUP     = 2'd1,
        ST_NO_ROOM = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [PN_W-1:0]   low;
        logic [PN_W-1:0]   high;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic gt;
        logic up;
        logic dn;
    } flags_t;

    typedef struct packed {
        logic cmp;
        logic rec_go;
        logic ins_go;
        logic mrg_go;
        logic head_go;
    } ctrl_t;

    typedef struct packed {
        logic dup;
        logic ins;
        logic mrg;
    } req_t;

endpackage

`default_nettype wire

// ----- design/rprt_cell.sv -----
`default_nettype none

module rprt_cell #(
    parameter bit HEAD = 1'b0
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rprt_pkg::ctrl_t              ctrl,
    input  wire logic [rprt_pkg::PN_W-1:0]    pn,
    input  wire logic [rprt_pkg::TIME_W-1:0]  arrival,
    input  wire rprt_pkg::entry_t             prev_entry,
    input  wire rprt_pkg::entry_t             next_entry,
    input  wire rprt_pkg::flags_t             prev_flags,
    input  wire rprt_pkg::flags_t             next_flags,
    output rprt_pkg::entry_t                  entry,
    output rprt_pkg::flags_t                  flags,
    output rprt_pkg::req_t                    req
);

    localparam logic [rprt_pkg::PN_W:0] EXT_ONE = (rprt_pkg::PN_W + 1)'(1);

    rprt_pkg::entry_t entry_reg;
    rprt_pkg::entry_t entry_next;
    rprt_pkg::flags_t flags_reg;
    rprt_pkg::flags_t flags_next;

    logic [rprt_pkg::PN_W:0] pn_ext;
    logic [rprt_pkg::PN_W:0] low_ext;
    logic [rprt_pkg::PN_W:0] high_ext;

    logic stop;
    logic bottom;
    logic merge_here;
    logic ext_here;
    logic ins_stop;
    logic ins_after;
    logic ins_at;
    logic lower_here;
    logic merge_low;

    assign pn_ext   = {1'b0, pn};
    assign low_ext  = {1'b0, entry_reg.low};
    assign high_ext = {1'b0, entry_reg.high};

    assign stop       = flags_reg.hit && !prev_flags.hit;
    assign bottom     = entry_reg.valid && !next_entry.valid;
    assign merge_here = stop && flags_reg.gt && flags_reg.up && prev_flags.dn;
    assign ext_here   = stop && flags_reg.gt && flags_reg.up && !prev_flags.dn;
    assign ins_stop   = stop && flags_reg.gt && !flags_reg.up && !prev_flags.dn;
    assign ins_after  = bottom && !flags_reg.hit && !flags_reg.dn;
    assign ins_at     = ins_stop
                        || (!entry_reg.valid && prev_entry.valid
                            && !prev_flags.hit && !prev_flags.dn);
    assign lower_here = (bottom && !flags_reg.hit && flags_reg.dn)
                        || (flags_reg.dn && !flags_reg.hit && next_flags.hit
                            && next_flags.gt && !next_flags.up);
    assign merge_low  = flags_reg.dn && !flags_reg.hit && next_flags.hit
                        && next_flags.gt && next_flags.up;

    assign req.dup = stop && !flags_reg.gt;
    assign req.ins = ins_stop || ins_after;
    assign req.mrg = merge_here;

    always_comb
    begin
        flags_next = flags_reg;
        if (ctrl.cmp)
        begin
            flags_next.hit = entry_reg.valid && (pn >= entry_reg.low);
            flags_next.gt  = pn > entry_reg.high;
            flags_next.up  = pn_ext == (high_ext + EXT_ONE);
            flags_next.dn  = (pn_ext + EXT_ONE) == low_ext;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.head_go)
        begin
            entry_next.low   = pn;
            entry_next.high  = pn;
            entry_next.stamp = arrival;
        end
        else if (ctrl.ins_go)
        begin
            if (ins_at)
            begin
                entry_next.valid = 1'b1;
                entry_next.low   = pn;
                entry_next.high  = pn;
                entry_next.stamp = arrival;
            end
            else if (prev_flags.hit)
            begin
                entry_next = prev_entry;
            end
        end
        else if (ctrl.mrg_go)
        begin
            if (flags_reg.hit)
            begin
                entry_next = next_entry;
            end
            else if (merge_low)
            begin
                entry_next.low = next_entry.low;
            end
        end
        else if (ctrl.rec_go)
        begin
            if (ext_here)
            begin
                entry_next.high  = pn;
                entry_next.stamp = arrival;
            end
            else if (lower_here)
            begin
                entry_next.low = pn;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '{valid: HEAD, low: '0, high: '0, stamp: '0};
            flags_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            flags_reg <= flags_next;
        end
    end

    assign entry = entry_reg;
    assign flags = flags_reg;

endmodule

`default_nettype wire

// ----- design/received_packet_range_tracker_core.sv -----
// Received packet range tracker.
// Input channel (in_valid/in_ready) carries action, packet_number and
// arrival_time; action 1 records the number, action 0 only looks it up.
// Output channel (out_valid/out_ready) returns one transaction per input:
// status (new, duplicate, no room), the upper end of the highest range and
// that range's stored arrival time.
// Ranges live in a row of MAX_RANGES cells, highest first; each cell holds
// one range, compares it against the packet number, and hands its range to
// a neighbor when a range is opened or two ranges merge.
// Each input is captured, compared in every cell, applied to the row and
// loaded into the output register (states IDLE, COMPARE, APPLY, FINISH); a
// new input is accepted only once the last result is in the output register.
// Reset empties the row: only the head cell is in use, holding 0..0, and
// both channels go idle.
// When the receiver stalls, the result holds in the output register; one
// more item is accepted and processed, then waits until the result leaves.
`default_nettype none

module received_packet_range_tracker_core #(
    parameter int MAX_RANGES = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         action,
    input  wire logic [rprt_pkg::PN_W-1:0]    packet_number,
    input  wire logic [rprt_pkg::TIME_W-1:0]  arrival_time,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        status,
    output logic [rprt_pkg::PN_W-1:0]         largest_received,
    output logic [rprt_pkg::TIME_W-1:0]       largest_arrival_time
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    logic                            action_reg;
    logic [rprt_pkg::PN_W-1:0]       pn_reg;
    logic [rprt_pkg::TIME_W-1:0]     arrival_reg;
    rprt_pkg::status_t               res_status_reg;
    rprt_pkg::status_t               res_status_next;
    logic                            out_valid_reg;
    rprt_pkg::status_t               status_reg;
    logic [rprt_pkg::PN_W-1:0]       largest_reg;
    logic [rprt_pkg::TIME_W-1:0]     largest_time_reg;

    rprt_pkg::entry_t cell_entry [MAX_RANGES];
    rprt_pkg::flags_t cell_flags [MAX_RANGES];
    rprt_pkg::req_t   cell_req   [MAX_RANGES];

    logic [MAX_RANGES-1:0] valid_vec;
    logic [MAX_RANGES-1:0] dup_vec;
    logic [MAX_RANGES-1:0] ins_vec;
    logic [MAX_RANGES-1:0] mrg_vec;

    logic            apply;
    logic            head_empty;
    logic            full;
    rprt_pkg::ctrl_t ctrl_all;

    assign apply      = state_reg == S_APPLY;
    assign head_empty = (cell_entry[0].low == '0) && (cell_entry[0].high == '0);
    assign full       = valid_vec[MAX_RANGES-1];

    assign ctrl_all.cmp     = state_reg == S_COMPARE;
    assign ctrl_all.rec_go  = apply && action_reg && !head_empty;
    assign ctrl_all.ins_go  = apply && action_reg && !head_empty && (|ins_vec) && !full;
    assign ctrl_all.mrg_go  = apply && action_reg && !head_empty && (|mrg_vec);
    assign ctrl_all.head_go = apply && action_reg && head_empty;

    for (genvar g = 0; g < MAX_RANGES; g++)
    begin : g_cell
        rprt_pkg::entry_t prev_e;
        rprt_pkg::entry_t next_e;
        rprt_pkg::flags_t prev_f;
        rprt_pkg::flags_t next_f;
        rprt_pkg::ctrl_t  c;

        if (g == 0)
        begin : g_first
            assign prev_e = '0;
            assign prev_f = '0;
        end
        else
        begin : g_inner
            assign prev_e = cell_entry[g-1];
            assign prev_f = cell_flags[g-1];
        end

        if (g == MAX_RANGES - 1)
        begin : g_last
            assign next_e = '0;
            assign next_f = '0;
        end
        else
        begin : g_body
            assign next_e = cell_entry[g+1];
            assign next_f = cell_flags[g+1];
        end

        always_comb
        begin
            c         = ctrl_all;
            c.head_go = ctrl_all.head_go && (g == 0);
        end

        rprt_cell #(
            .HEAD (g == 0)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (c),
            .pn         (pn_reg),
            .arrival    (arrival_reg),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .prev_flags (prev_f),
            .next_flags (next_f),
            .entry      (cell_entry[g]),
            .flags      (cell_flags[g]),
            .req        (cell_req[g])
        );

        assign valid_vec[g] = cell_entry[g].valid;
        assign dup_vec[g]   = cell_req[g].dup;
        assign ins_vec[g]   = cell_req[g].ins;
        assign mrg_vec[g]   = cell_req[g].mrg;
    end

    always_comb
    begin
        res_status_next = rprt_pkg::ST_NEW;
        if (action_reg)
        begin
            if (head_empty)
            begin
                res_status_next = rprt_pkg::ST_NEW;
            end
            else if (|dup_vec)
            begin
                res_status_next = rprt_pkg::ST_DUP;
            end
            else if ((|ins_vec) && full)
            begin
                res_status_next = rprt_pkg::ST_NO_ROOM;
            end
        end
        else if (|dup_vec)
        begin
            res_status_next = rprt_pkg::ST_DUP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            action_reg       <= 1'b0;
            pn_reg           <= '0;
            arrival_reg      <= '0;
            res_status_reg   <= rprt_pkg::ST_NEW;
            out_valid_reg    <= 1'b0;
            status_reg       <= rprt_pkg::ST_NEW;
            largest_reg      <= '0;
            largest_time_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        action_reg  <= action;
                        pn_reg      <= packet_number;
                        arrival_reg <= arrival_time;
                        state_reg   <= S_COMPARE;
                    end
                end
                S_COMPARE:
                begin
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    res_status_reg <= res_status_next;
                    state_reg      <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg    <= 1'b1;
                        status_reg       <= res_status_reg;
                        largest_reg      <= cell_entry[0].high;
                        largest_time_reg <= cell_entry[0].stamp;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready             = state_reg == S_IDLE;
    assign out_valid            = out_valid_reg;
    assign status               = status_reg;
    assign largest_received     = largest_reg;
    assign largest_arrival_time = largest_time_reg;

    a_head_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec[0])
        else $error("head cell lost its range");

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("cells in use are not contiguous from the head");

    a_single_insert: assert property (@(posedge clk) disable iff (!rst_n)
        apply |-> $onehot0(ins_vec) && $onehot0(mrg_vec) && $onehot0(dup_vec))
        else $error("more than one cell claims the transaction");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_all.ins_go |=> $countones(valid_vec) == $countones($past(valid_vec)) + 1)
        else $error("insert did not add exactly one range");

    a_merge_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_all.mrg_go |=> $countones(valid_vec) + 1 == $countones($past(valid_vec)))
        else $error("merge did not remove exactly one range");

    a_no_room_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && res_status_reg == rprt_pkg::ST_NO_ROOM) |-> full)
        else $error("no room reported while a cell is free");

endmodule

`default_nettype wire
